FILE: src/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// shared types, constants and the reciprocal table for the 3x3 box blur
// ----------------------------------------------------------------------------
package bb3_pkg;

  // geometry limits and register reset values
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int WIDTH_RESET   = 640;
  localparam int HEIGHT_RESET  = 480;

  // register field widths
  localparam int RAW_WIDTH_W  = 11;
  localparam int RAW_HEIGHT_W = 13;
  localparam int HEIGHT_W     = 13;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 13;
  localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 1'b1;

  // request command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // datapath widths
  localparam int CHAN_W      = 8;
  localparam int SUM_W       = 12;
  localparam int NUM_W       = 13;
  localparam int CNT_W       = 4;
  localparam int RECIP_W     = 18;
  localparam int RECIP_SHIFT = 18;
  localparam int PROD_W      = NUM_W + RECIP_W;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pix_t;

  // ceil(2^18 / (2n)) for each neighbor count n; exact floor for numerators below 2^13
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] m;
    case (n)
      4'd1:    m = 18'd131072;
      4'd2:    m = 18'd65536;
      4'd3:    m = 18'd43691;
      4'd4:    m = 18'd32768;
      4'd6:    m = 18'd21846;
      4'd9:    m = 18'd14564;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

FILE: src/box_blur_3x3_rgb_unit.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_unit
// streaming 3x3 box blur over RGB pixels in raster order
// ----------------------------------------------------------------------------
// Takes one request per clock, pixel or flush, and keeps that rate as long as
// results are taken; a result sits in an output register, so input keeps
// flowing while a result waits until the three-stage pipeline is full. Each
// pixel's result (per-channel average of its in-image 3x3 neighbors, rounded
// half up) appears width+1 requests after the pixel itself, then passes through
// the pipeline stages (line store read, window/sum stage, reciprocal
// multiply). After the last pixel of a frame send width+1 flush requests to
// drain the final row; the last result carries frame_end. Flush requests
// outside the drain are accepted and ignored. The row stores are two single
// port-pair memories of MAX_WIDTH entries each, read at accept and written
// back when stage 1 advances; no clearing pass is needed after reset. Write the
// configuration registers only while idle: each write restarts the frame.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_unit #(
  parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             cmd,
  input  logic [bb3_pkg::CHAN_W-1:0]       in_red,
  input  logic [bb3_pkg::CHAN_W-1:0]       in_green,
  input  logic [bb3_pkg::CHAN_W-1:0]       in_blue,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bb3_pkg::CHAN_W-1:0]       out_red,
  output logic [bb3_pkg::CHAN_W-1:0]       out_green,
  output logic [bb3_pkg::CHAN_W-1:0]       out_blue,
  output logic                             frame_end,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bb3_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bb3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int WIDTH_RESET_EFF = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

  typedef struct packed {
    logic emit;
    logic left_ok;
    logic right_ok;
    logic top_ok;
    logic bot_ok;
    logic last;
  } ctl_t;

  // configuration and stream position
  logic [WW-1:0]       width;
  logic [HEIGHT_W-1:0] height;
  logic [WW-1:0]       width_next;
  logic [HEIGHT_W-1:0] height_next;
  logic [CW-1:0]       col;
  logic [HEIGHT_W-1:0] row;

  logic [RAW_WIDTH_W-1:0]  raw_w;
  logic [RAW_HEIGHT_W-1:0] raw_h;
  logic                    cfg_wr;

  // stage 0 decode
  logic          draining;
  logic          take;
  logic [WW-1:0] col_inc;
  logic          col_last;
  logic          frame_last;
  ctl_t          ctl0;
  pix_t          pix0;

  // pipeline control
  logic en_out;
  logic en2;
  logic en1;
  logic adv1;

  // stage 1
  logic          s1_valid;
  logic [CW-1:0] s1_addr;
  pix_t          s1_pix;
  ctl_t          s1_ctl;
  pix_t          up;
  pix_t          up2;
  pix_t          win_l [3];
  pix_t          win_c [3];
  pix_t          nc    [3];
  logic [2:0]    rows_ok;
  logic [1:0]    rows_cnt;
  logic [1:0]    cols_cnt;
  logic [CNT_W-1:0] rows4;
  logic [CNT_W-1:0] cols4;
  logic [CNT_W-1:0] n;
  logic [SUM_W-1:0] sum [3];
  logic [NUM_W-1:0] x   [3];

  // stage 2
  logic             s2_valid;
  logic [NUM_W-1:0] s2_x [3];
  logic [CNT_W-1:0] s2_n;
  logic             s2_last;
  logic [PROD_W-1:0] prod [3];

  // configuration decode with clamping
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign raw_w     = cfg_data[RAW_WIDTH_W-1:0];
  assign raw_h     = cfg_data[RAW_HEIGHT_W-1:0];

  always_comb begin
    if (raw_w == '0) begin
      width_next = WW'(1);
    end else if (int'(raw_w) > MAX_WIDTH) begin
      width_next = WW'(MAX_WIDTH);
    end else begin
      width_next = WW'(raw_w);
    end
    if (raw_h == '0) begin
      height_next = HEIGHT_W'(1);
    end else if (int'(raw_h) > MAX_HEIGHT) begin
      height_next = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      height_next = HEIGHT_W'(raw_h);
    end
  end

  // stage 0: classify the request from the current position
  assign draining   = row >= height;
  assign take       = in_valid && !in_stall && !(cmd == CMD_FLUSH && !draining);
  assign col_inc    = WW'(col) + WW'(1);
  assign col_last   = col_inc >= width;
  assign frame_last = row == (height + HEIGHT_W'(1));
  assign pix0       = draining ? '0 : {in_blue, in_green, in_red};

  always_comb begin
    ctl0      = '0;
    ctl0.last = frame_last;
    if (col == '0) begin
      // result for the last column of the row two above
      ctl0.emit     = row >= HEIGHT_W'(2);
      ctl0.top_ok   = row >= HEIGHT_W'(3);
      ctl0.bot_ok   = row <= height;
      ctl0.left_ok  = width >= WW'(2);
      ctl0.right_ok = 1'b0;
    end else begin
      // result for the previous column of the row above
      ctl0.emit     = row >= HEIGHT_W'(1);
      ctl0.top_ok   = row >= HEIGHT_W'(2);
      ctl0.bot_ok   = row < height;
      ctl0.left_ok  = col >= CW'(2);
      ctl0.right_ok = 1'b1;
    end
  end

  // position and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= WW'(WIDTH_RESET_EFF);
      height <= HEIGHT_W'(HEIGHT_RESET);
      col    <= '0;
      row    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_WIDTH: begin
          width <= width_next;
          col   <= '0;
          row   <= '0;
        end
        CFG_HEIGHT: begin
          height <= height_next;
          col    <= '0;
          row    <= '0;
        end
        default: begin
        end
      endcase
    end else if (take) begin
      if (frame_last) begin
        col <= '0;
        row <= '0;
      end else if (col_last) begin
        col <= '0;
        row <= row + HEIGHT_W'(1);
      end else begin
        col <= col_inc[CW-1:0];
      end
    end
  end

  // pipeline enables: each stage moves when empty or when the next one moves
  assign en_out   = !out_valid || !out_stall;
  assign en2      = !s2_valid || en_out;
  assign en1      = !s1_valid || en2;
  assign adv1     = s1_valid && en2;
  assign in_stall = !en1;

  // row stores
  bb3_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk      (clk),
    .rd_en    (take),
    .rd_addr  (col),
    .wr_en    (adv1),
    .wr_addr  (s1_addr),
    .wr_above (s1_pix),
    .wr_two   (up),
    .up       (up),
    .up2      (up2)
  );

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_addr <= col;
      s1_pix  <= pix0;
      s1_ctl  <= ctl0;
    end
  end

  // new window column, top to bottom
  assign nc[0] = up2;
  assign nc[1] = up;
  assign nc[2] = s1_pix;

  // window shift; the oldest column is never needed again
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        win_l[i] <= '0;
        win_c[i] <= '0;
      end
    end else if (adv1) begin
      for (int i = 0; i < 3; i++) begin
        win_l[i] <= win_c[i];
        win_c[i] <= nc[i];
      end
    end
  end

  // neighbor count
  assign rows_ok  = {s1_ctl.bot_ok, 1'b1, s1_ctl.top_ok};
  assign rows_cnt = 2'd1 + {1'b0, s1_ctl.top_ok} + {1'b0, s1_ctl.bot_ok};
  assign cols_cnt = 2'd1 + {1'b0, s1_ctl.left_ok} + {1'b0, s1_ctl.right_ok};
  assign rows4    = {2'b00, rows_cnt};
  assign cols4    = {2'b00, cols_cnt};
  assign n        = rows4 * cols4;

  // per-channel sums over the in-image neighbors, then 2*sum + n
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = '0;
      for (int i = 0; i < 3; i++) begin
        if (rows_ok[i]) begin
          sum[k] = sum[k] + SUM_W'(win_c[i][CHAN_W*k +: CHAN_W]);
          if (s1_ctl.left_ok) begin
            sum[k] = sum[k] + SUM_W'(win_l[i][CHAN_W*k +: CHAN_W]);
          end
          if (s1_ctl.right_ok) begin
            sum[k] = sum[k] + SUM_W'(nc[i][CHAN_W*k +: CHAN_W]);
          end
        end
      end
      x[k] = {sum[k], 1'b0} + NUM_W'(n);
    end
  end

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s1_valid && s1_ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int k = 0; k < 3; k++) begin
        s2_x[k] <= x[k];
      end
      s2_n    <= n;
      s2_last <= s1_ctl.last;
    end
  end

  // rounded divide by 2n through a reciprocal multiply
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = PROD_W'(s2_x[k]) * PROD_W'(recip(s2_n));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_out) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && s2_valid) begin
      out_red   <= prod[0][RECIP_SHIFT +: CHAN_W];
      out_green <= prod[1][RECIP_SHIFT +: CHAN_W];
      out_blue  <= prod[2][RECIP_SHIFT +: CHAN_W];
      frame_end <= s2_last;
    end
  end

endmodule

FILE: src/bb3_line_buf.sv
// ----------------------------------------------------------------------------
// bb3_line_buf
// the two row stores, read ahead of their write-back, with forwarding
// ----------------------------------------------------------------------------
module bb3_line_buf #(
  parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  bb3_pkg::pix_t                wr_above,
  input  bb3_pkg::pix_t                wr_two,
  output bb3_pkg::pix_t                up,
  output bb3_pkg::pix_t                up2
);
  import bb3_pkg::*;

  pix_t row_above     [MAX_WIDTH];
  pix_t row_two_above [MAX_WIDTH];

  pix_t above_q;
  pix_t two_q;
  logic fwd;
  pix_t fwd_above;
  pix_t fwd_two;

  // write-back port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_above[wr_addr]     <= wr_above;
      row_two_above[wr_addr] <= wr_two;
    end
  end

  // read port, plus bypass when the write lands on the entry being read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      above_q   <= row_above[rd_addr];
      two_q     <= row_two_above[rd_addr];
      fwd       <= wr_en && (wr_addr == rd_addr);
      fwd_above <= wr_above;
      fwd_two   <= wr_two;
    end
  end

  assign up  = fwd ? fwd_above : above_q;
  assign up2 = fwd ? fwd_two   : two_q;

endmodule

FILE: src/bb3_checker.sv
// ----------------------------------------------------------------------------
// bb3_checker
// port-level checks for the box blur unit, bound to the top level
// ----------------------------------------------------------------------------
module bb3_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [bb3_pkg::CHAN_W-1:0] out_red,
  input logic [bb3_pkg::CHAN_W-1:0] out_green,
  input logic [bb3_pkg::CHAN_W-1:0] out_blue,
  input logic                       frame_end
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(frame_end))
    else $error("stalled result changed");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // with no result waiting the unit always takes a request
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // a result that was taken cannot hold the input back in the same cycle
  a_taken_no_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |-> !in_stall)
    else $error("input stalled while result taken");

endmodule

bind box_blur_3x3_rgb_unit bb3_checker u_bb3_checker (.*);

FILE: dv/box_blur_3x3_rgb_checker.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_checker
// watches the request, result and register channels of the box blur, keeps
// its own line stores, window and frame position, works out the expected
// blurred pixel for each result an accepted request brings due and compares each
// accepted result against the oldest one still waiting
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module box_blur_3x3_rgb_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic                             cmd,
  input  logic [bb3_pkg::CHAN_W-1:0]       in_red,
  input  logic [bb3_pkg::CHAN_W-1:0]       in_green,
  input  logic [bb3_pkg::CHAN_W-1:0]       in_blue,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [bb3_pkg::CHAN_W-1:0]       out_red,
  input  logic [bb3_pkg::CHAN_W-1:0]       out_green,
  input  logic [bb3_pkg::CHAN_W-1:0]       out_blue,
  input  logic                             frame_end,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [bb3_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                               error_count,
  output int                               pending_results,
  output int                               results_checked,
  output int                               frames_done
);
  import bb3_pkg::*;

  typedef struct packed {
    pix_t px;
    logic frame_end;
  } blur_result_t;

  // register copies
  logic [RAW_WIDTH_W-1:0]  width_reg;
  logic [RAW_HEIGHT_W-1:0] height_reg;

  // line stores, window and stream position
  pix_t        line_prev  [MAX_WIDTH_DEF];
  pix_t        line_prev2 [MAX_WIDTH_DEF];
  pix_t        win        [9];
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned drain_stage;

  blur_result_t blurred_q [$];

  // geometry in use, with zero and oversize values clamped
  function automatic int unsigned span_w();
    if (width_reg == '0) return 1;
    if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return width_reg;
  endfunction

  function automatic int unsigned span_h();
    if (height_reg == '0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  // rounded mean over the in-image part of the window around its middle row
  function automatic pix_t box_mean(input int unsigned crow, input int unsigned ccol,
                                    input int lc, input int cc, input int rc,
                                    input int unsigned w, input int unsigned h);
    int unsigned sum_r;
    int unsigned sum_g;
    int unsigned sum_b;
    int unsigned n;
    int          wc [3];
    bit          col_in [3];
    bit          row_in [3];
    pix_t        p;
    pix_t        avg;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    n = 0;
    wc[0] = lc;
    wc[1] = cc;
    wc[2] = rc;
    col_in[0] = ccol >= 1;
    col_in[1] = 1'b1;
    col_in[2] = (rc >= 0) && (ccol + 1 < w);
    row_in[0] = crow >= 1;
    row_in[1] = 1'b1;
    row_in[2] = crow + 1 < h;
    for (int rr = 0; rr < 3; rr++) begin
      for (int k = 0; k < 3; k++) begin
        if (row_in[rr] && col_in[k]) begin
          p = win[rr * 3 + wc[k]];
          sum_r += p.red;
          sum_g += p.green;
          sum_b += p.blue;
          n++;
        end
      end
    end
    avg.red   = 8'((2 * sum_r + n) / (2 * n));
    avg.green = 8'((2 * sum_g + n) / (2 * n));
    avg.blue  = 8'((2 * sum_b + n) / (2 * n));
    return avg;
  endfunction

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    drain_stage = 0;
  endfunction

  // advance the stream by one accepted request
  task automatic take_request(input logic kind, input pix_t req_px);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    bit          draining;
    bit          emitted;
    bit          last;
    pix_t        data;
    pix_t        up;
    pix_t        up2;
    pix_t        avg;
    w = span_w();
    h = span_h();
    draining = drain_stage != 0;
    // flush outside the drain is ignored
    if (!draining && kind == CMD_FLUSH) return;
    data = draining ? '0 : req_px;
    r = draining ? h - 1 + drain_stage : row_pos;
    c = col_pos;
    emitted = 1'b0;
    last = 1'b0;
    // row start: window still centered on the last pixel of the row two above
    if (c == 0 && r >= 2) begin
      avg = box_mean(r - 2, w - 1, 1, 2, -1, w, h);
      emitted = 1'b1;
    end
    up = line_prev[c];
    up2 = line_prev2[c];
    line_prev2[c] = up;
    line_prev[c] = data;
    win[0] = win[1];
    win[1] = win[2];
    win[2] = up2;
    win[3] = win[4];
    win[4] = win[5];
    win[5] = up;
    win[6] = win[7];
    win[7] = win[8];
    win[8] = data;
    if (c >= 1 && r >= 1) begin
      avg = box_mean(r - 1, c - 1, 0, 1, 2, w, h);
      emitted = 1'b1;
    end
    // position update, drain row and frame wrap
    if (drain_stage == 2) begin
      last = 1'b1;
      restart_frame();
    end else if (c + 1 >= w) begin
      col_pos = 0;
      if (draining) begin
        drain_stage++;
      end else if (row_pos + 1 >= h) begin
        row_pos = 0;
        drain_stage = 1;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos = c + 1;
    end
    if (emitted) blurred_q.push_back('{px: avg, frame_end: last});
  endtask

  // compare one accepted result with the oldest expectation
  task automatic check_result();
    blur_result_t want;
    if (blurred_q.size() == 0) begin
      $error("result with none expected: red %0d green %0d blue %0d frame_end %0b",
             out_red, out_green, out_blue, frame_end);
      error_count++;
    end else begin
      want = blurred_q.pop_front();
      results_checked++;
      if (out_red !== want.px.red) begin
        $error("out_red: expected %0d, got %0d", want.px.red, out_red);
        error_count++;
      end
      if (out_green !== want.px.green) begin
        $error("out_green: expected %0d, got %0d", want.px.green, out_green);
        error_count++;
      end
      if (out_blue !== want.px.blue) begin
        $error("out_blue: expected %0d, got %0d", want.px.blue, out_blue);
        error_count++;
      end
      if (frame_end !== want.frame_end) begin
        $error("frame_end: expected %0b, got %0b", want.frame_end, frame_end);
        error_count++;
      end
      if (want.frame_end && frame_end === 1'b1) frames_done++;
    end
  endtask

  // sample all three channels at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      width_reg = RAW_WIDTH_W'(WIDTH_RESET);
      height_reg = RAW_HEIGHT_W'(HEIGHT_RESET);
      for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
        line_prev[i] = '0;
        line_prev2[i] = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;
      restart_frame();
      blurred_q.delete();
      error_count = 0;
      results_checked = 0;
      frames_done = 0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WIDTH) begin
          width_reg = cfg_data[RAW_WIDTH_W-1:0];
        end else begin
          height_reg = cfg_data[RAW_HEIGHT_W-1:0];
        end
        restart_frame();
      end
      if (in_valid && !in_stall) take_request(cmd, pix_t'({in_blue, in_green, in_red}));
    end
    pending_results <= blurred_q.size();
  end

endmodule

FILE: dv/tb_box_blur_3x3_rgb_unit.sv
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_rgb_unit
// drives pixel and flush requests and register writes into the box blur;
// a checker beside the block predicts and compares every result. covers
// directed corner frames, random frame sizes with noise requests, both
// geometry limits and four mixes of sender idling and receiver stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_box_blur_3x3_rgb_unit;
  import bb3_pkg::*;

  // no accept on any channel for this long means the block hung
  localparam int QUIET_LIMIT     = 4000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int RANDOM_REQUESTS = 430;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum {TEX_RANDOM, TEX_EXTREME, TEX_FLAT} texture_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   cmd = CMD_PIXEL;
  logic [CHAN_W-1:0]      in_red = '0;
  logic [CHAN_W-1:0]      in_green = '0;
  logic [CHAN_W-1:0]      in_blue = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [CHAN_W-1:0]      out_red;
  logic [CHAN_W-1:0]      out_green;
  logic [CHAN_W-1:0]      out_blue;
  logic                   frame_end;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int          error_count;
  int          pending_results;
  int          results_checked;
  int          frames_done;
  int          in_idle_pct = 0;
  int          out_stall_pct = 0;
  int unsigned requests_sent = 0;
  int unsigned frame_items = 0;
  int unsigned quiet_cycles = 0;
  int unsigned cur_w = WIDTH_RESET;
  int unsigned cur_h = HEIGHT_RESET;

  box_blur_3x3_rgb_unit uut (.*);

  box_blur_3x3_rgb_checker u_checker (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // hang detection
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_box_blur_3x3_rgb_unit: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER: begin
        in_idle_pct = 48;
        out_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        in_idle_pct = 0;
        out_stall_pct = 48;
      end
      IDLE_BOTH: begin
        in_idle_pct = 9;
        out_stall_pct = 9;
      end
      default: begin
        in_idle_pct = 0;
        out_stall_pct = 0;
      end
    endcase
  endfunction

  function automatic pix_t rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    return pix_t'({b, g, r});
  endfunction

  function automatic pix_t make_pixel(input texture_t tex, input pix_t base);
    pix_t px;
    case (tex)
      TEX_EXTREME: begin
        px.red = {8{1'($urandom)}};
        px.green = {8{1'($urandom)}};
        px.blue = {8{1'($urandom)}};
      end
      TEX_FLAT: px = base ^ (24'($urandom) & 24'h030303);
      default: px = 24'($urandom);
    endcase
    return px;
  endfunction

  // one request, held until accepted
  task automatic send_request(input logic kind, input pix_t px);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= kind;
    in_red <= px.red;
    in_green <= px.green;
    in_blue <= px.blue;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // idle, every result out and the pipeline empty
  task automatic settle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_regs(input bit set_w, input int unsigned w,
                            input bit set_h, input int unsigned h);
    settle();
    if (set_w) begin
      reg_write(CFG_WIDTH, w);
      cur_w = w;
    end
    if (set_h) begin
      reg_write(CFG_HEIGHT, h);
      cur_h = h;
    end
    cfg_valid <= 1'b0;
  endtask

  // npix pixels; a complete frame also gets its drain row
  task automatic send_frame(input int unsigned w, input int unsigned h,
                            input int unsigned npix, input bit noisy);
    texture_t tex;
    pix_t     base;
    tex = texture_t'($urandom_range(2));
    base = 24'($urandom);
    for (int unsigned i = 0; i < npix; i++) begin
      // stray flush in the middle of the pixels, ignored by the block
      if (noisy && $urandom_range(19) == 0) send_request(CMD_FLUSH, 24'($urandom));
      send_request(CMD_PIXEL, make_pixel(tex, base));
      frame_items++;
      if (noisy && $urandom_range(199) == 0) hold_until_drained();
    end
    if (npix == w * h) begin
      for (int unsigned i = 0; i <= w; i++) begin
        // a pixel during the drain counts as a flush, data dropped
        if (noisy && $urandom_range(4) == 0) begin
          send_request(CMD_PIXEL, 24'($urandom));
        end else begin
          send_request(CMD_FLUSH, 24'($urandom));
        end
        frame_items++;
      end
    end
  endtask

  initial begin
    int unsigned target;
    int unsigned round;
    int unsigned pick;
    int unsigned nw;
    int unsigned nh;
    int unsigned npix;
    bit          partial;
    bit          frame_open;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    set_idling(IDLE_NONE);

    // reset geometry, a few pixels with no result due yet
    send_frame(cur_w, cur_h, 12, 1'b0);

    // 3x3 frame: extremes, ignored flushes, a pause, a pixel inside the drain
    write_regs(1'b1, 3, 1'b1, 3);
    send_request(CMD_FLUSH, rgb(8'd255, 8'd255, 8'd255));
    send_request(CMD_PIXEL, rgb(8'd255, 8'd255, 8'd255));
    send_request(CMD_PIXEL, rgb(8'd0, 8'd0, 8'd0));
    send_request(CMD_PIXEL, rgb(8'd255, 8'd0, 8'd128));
    send_request(CMD_PIXEL, rgb(8'd0, 8'd255, 8'd1));
    send_request(CMD_FLUSH, rgb(8'd0, 8'd0, 8'd0));
    send_request(CMD_PIXEL, rgb(8'd255, 8'd255, 8'd255));
    hold_until_drained();
    send_request(CMD_PIXEL, rgb(8'd1, 8'd2, 8'd3));
    send_request(CMD_PIXEL, rgb(8'd254, 8'd127, 8'd128));
    send_request(CMD_PIXEL, rgb(8'd0, 8'd0, 8'd0));
    send_request(CMD_PIXEL, rgb(8'd255, 8'd255, 8'd255));
    send_request(CMD_FLUSH, rgb(8'd0, 8'd0, 8'd0));
    send_request(CMD_FLUSH, rgb(8'd0, 8'd0, 8'd0));
    send_request(CMD_PIXEL, rgb(8'd9, 8'd9, 8'd9));
    send_request(CMD_FLUSH, rgb(8'd0, 8'd0, 8'd0));

    // zero registers act as a single pixel image
    write_regs(1'b1, 0, 1'b1, 0);
    send_request(CMD_PIXEL, rgb(8'd255, 8'd0, 8'd255));
    send_request(CMD_FLUSH, rgb(8'd0, 8'd0, 8'd0));
    send_request(CMD_PIXEL, rgb(8'd7, 8'd7, 8'd7));

    // 2x2, all corners
    write_regs(1'b1, 2, 1'b1, 2);
    send_request(CMD_PIXEL, rgb(8'd0, 8'd255, 8'd0));
    send_request(CMD_PIXEL, rgb(8'd255, 8'd0, 8'd255));
    send_request(CMD_PIXEL, rgb(8'd128, 8'd128, 8'd128));
    send_request(CMD_PIXEL, rgb(8'd127, 8'd129, 8'd0));
    repeat (3) send_request(CMD_FLUSH, rgb(8'd0, 8'd0, 8'd0));

    // random frames, idle mix changing every few frames
    target = frame_items + RANDOM_REQUESTS;
    round = 0;
    frame_open = 1'b0;
    while (frame_items < target) begin
      set_idling(idle_mode_t'((round / 3) % 4));
      pick = $urandom_range(3);
      nw = ($urandom_range(5) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      nh = ($urandom_range(5) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
      if (frame_open || pick == 0) begin
        write_regs(1'b1, nw, 1'b1, nh);
      end else if (pick == 1) begin
        write_regs(1'b1, nw, 1'b0, 0);
      end else if (pick == 2) begin
        write_regs(1'b0, 0, 1'b1, nh);
      end
      // otherwise the next frame follows back to back
      partial = ($urandom_range(5) == 0);
      npix = partial ? $urandom_range(cur_w * cur_h - 1) : cur_w * cur_h;
      send_frame(cur_w, cur_h, npix, 1'b1);
      frame_open = partial;
      round++;
    end

    // geometry limits from oversize register values, partial frames
    set_idling(IDLE_BOTH);
    write_regs(1'b1, 2000, 1'b1, 2);
    send_frame(cur_w, cur_h, 30, 1'b0);
    set_idling(IDLE_RECEIVER);
    write_regs(1'b1, 2, 1'b1, 8000);
    send_frame(cur_w, cur_h, 40, 1'b1);

    settle();
    $display("run: %0d requests (%0d frame items), %0d results checked, %0d frames closed",
             requests_sent, frame_items, results_checked, frames_done);
    $display("geometry from 1x1 to width %0d and height %0d, four idle mixes",
             MAX_WIDTH_DEF, MAX_HEIGHT);
    if (error_count == 0 && pending_results == 0) begin
      $display("tb_box_blur_3x3_rgb_unit: clean");
    end else begin
      $display("tb_box_blur_3x3_rgb_unit: errors");
    end
    $finish;
  end

endmodule
